@@ rtl/core/camy_pkg.sv @@
// ----------------------------------------------------------------------------
// camy_pkg: shared definitions for the calendar month/year adder
// Calendar constants, reciprocal multipliers for the constant divisions,
// saturation codes and small month tables.
// ----------------------------------------------------------------------------
package camy_pkg;

	// Number of register stages from input to output.
	localparam int STAGES = 17;

	// Operation codes.
	localparam logic OP_MONTHS = 1'b0;
	localparam logic OP_YEARS  = 1'b1;

	// Saturation codes carried down the pipe.
	localparam logic [1:0] SAT_NONE = 2'd0;
	localparam logic [1:0] SAT_LOW  = 2'd1;
	localparam logic [1:0] SAT_HIGH = 2'd2;

	// Day window 0000-01-01 .. 9999-12-31.
	localparam logic signed [22:0] DAY_MIN = -23'sd719528;
	localparam logic signed [22:0] DAY_MAX = 23'sd2932896;
	localparam logic [21:0]        DAY_EPOCH = 22'd719528;

	// Delta limits.
	localparam logic signed [63:0] MONTH_CAP = 64'sd120000;
	localparam logic signed [63:0] YEAR_CAP  = 64'sd10000;
	localparam logic [13:0]        YEAR_MAX  = 14'd9999;

	// Shift that makes the day number count from the start of a March-based 400-year era.
	localparam logic [21:0] Z_OFFSET = 22'd865565;

	localparam logic [17:0] DAYS_400Y = 18'd146097;
	localparam logic [15:0] DAYS_100Y = 16'd36524;
	localparam logic [10:0] DAYS_4Y   = 11'd1461;
	localparam logic [8:0]  DAYS_1Y   = 9'd365;
	localparam logic [8:0]  CYC_YEARS = 9'd400;
	localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

	// Reciprocals: floor(2^s / d). The estimates fall short by at most one.
	localparam logic [14:0] ERA_RECIP    = 15'd29398;   // 2^32 / 146097
	localparam logic [11:0] CYC_RECIP    = 12'd2870;    // 2^22 / 1461
	localparam logic [14:0] DIV12_RECIP  = 15'd21845;   // 2^18 / 12
	localparam logic [13:0] DIV400_RECIP = 14'd10485;   // 2^22 / 400

	// First day of each month in a year that starts on March 1.
	function automatic logic [8:0] march_start(input logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// Month of a March-based year (0 = March) from the day of that year.
	function automatic logic [3:0] march_month(input logic [8:0] doy);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy >= march_start(4'(i)))
				n = n + 4'd1;
		end
		return n;
	endfunction

	// Days before the first of month nm (1..12) in a common year.
	function automatic logic [8:0] cum_days(input logic [3:0] nm);
		logic [8:0] s;
		case (nm)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// Length of month nm (1..12).
	function automatic logic [4:0] month_len(input logic [3:0] nm, input logic leap);
		logic [4:0] l;
		case (nm)
			4'd2:    l = leap ? 5'd29 : 5'd28;
			4'd4:    l = 5'd30;
			4'd6:    l = 5'd30;
			4'd9:    l = 5'd30;
			4'd11:   l = 5'd30;
			default: l = 5'd31;
		endcase
		return l;
	endfunction

	// Leap years among the first r years (0..399) of a 400-year cycle.
	function automatic logic [6:0] cycle_leaps(input logic [8:0] r);
		logic [9:0] q4;
		logic [6:0] n;
		q4 = ({1'b0, r} + 10'd3) >> 2;
		n  = q4[6:0];
		if (r > 9'd100)
			n = n - 7'd1;
		if (r > 9'd200)
			n = n - 7'd1;
		if (r > 9'd300)
			n = n - 7'd1;
		return n;
	endfunction

endpackage

@@ rtl/core/calendar_add_months_years.sv @@
// ----------------------------------------------------------------------------
// calendar_add_months_years: add months or years to a day number
// Seventeen-stage pipeline that turns a day number into year, month and day,
// shifts the month or the year, clamps the day and turns the date back.
// ----------------------------------------------------------------------------
// Usage
// The input channel takes one transaction per cycle while in_stall is low:
// op (0 adds months, 1 adds years), day_number (signed days since
// 1970-01-01) and a signed 64-bit delta. The output channel returns one
// transaction for each input, in order: result_day_number. Both channels
// handshake with valid and stall; a transaction moves at a rising edge
// where valid is high and stall is low. It lands in the first of seventeen
// register stages at the accepting edge and passes through them in order
// to out_valid. When the output is not stalled, the block takes one
// transaction per cycle, as every stage holds one and advances each cycle.
// While out_stall is high, the output holds its transaction; stages behind it
// keep moving forward into empty slots, so the block still takes input until
// every stage is full, and only then raises in_stall.
// Reset (arst_n low) empties every stage at once; payload registers keep
// whatever they held, as only the valid bits matter.
// Dates are saturated to 0000-01-01 .. 9999-12-31 on the way in and out.
// ----------------------------------------------------------------------------
module calendar_add_months_years (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [22:0] day_number,
	input  logic signed [63:0] delta,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [22:0] result_day_number
);

	// ------------------------------------------------------------------
	// Flow control. Stage k may load whenever some stage at or after it
	// is empty, or the output is being taken. This lets bubbles collapse.
	// ------------------------------------------------------------------
	logic [camy_pkg::STAGES:1] vld_q;
	logic [camy_pkg::STAGES:1] vld_d;
	logic [camy_pkg::STAGES:1] rdy;

	assign vld_d = {vld_q[camy_pkg::STAGES-1:1], in_valid};

	for (genvar k = 1; k <= camy_pkg::STAGES; k++) begin : g_flow
		assign rdy[k] = !out_stall || !(&vld_q[camy_pkg::STAGES:k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= vld_d[k];
			end
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[camy_pkg::STAGES];

	// ------------------------------------------------------------------
	// Stage 1: saturate the input date and the delta, then shift the day
	// number so that it counts from the start of a March-based era.
	// ------------------------------------------------------------------
	logic signed [22:0] dn_c;
	logic signed [63:0] cap_hi;
	logic signed [63:0] cap_lo;
	logic signed [17:0] cd_c;
	logic [23:0]        z_w;

	always_comb begin
		if (day_number < camy_pkg::DAY_MIN) begin
			dn_c = camy_pkg::DAY_MIN;
		end else if (day_number > camy_pkg::DAY_MAX) begin
			dn_c = camy_pkg::DAY_MAX;
		end else begin
			dn_c = day_number;
		end
		cap_hi = (op == camy_pkg::OP_YEARS) ? camy_pkg::YEAR_CAP : camy_pkg::MONTH_CAP;
		cap_lo = -cap_hi;
		if (delta > cap_hi) begin
			cd_c = cap_hi[17:0];
		end else if (delta < cap_lo) begin
			cd_c = cap_lo[17:0];
		end else begin
			cd_c = delta[17:0];
		end
		z_w = {dn_c[22], dn_c} + {2'b00, camy_pkg::Z_OFFSET};
	end

	logic               op_s1;
	logic [21:0]        z_s1;
	logic signed [17:0] cd_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			op_s1 <= op;
			z_s1  <= z_w[21:0];
			cd_s1 <= cd_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: estimate the 400-year era by a reciprocal multiply.
	// ------------------------------------------------------------------
	logic [36:0] era_prod;

	assign era_prod = 37'(z_s1) * 37'(camy_pkg::ERA_RECIP);

	logic               op_s2;
	logic [21:0]        z_s2;
	logic signed [17:0] cd_s2;
	logic [4:0]         era_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			op_s2  <= op_s1;
			z_s2   <= z_s1;
			cd_s2  <= cd_s1;
			era_s2 <= era_prod[36:32];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: correct the era estimate and form the day of the era.
	// ------------------------------------------------------------------
	logic [21:0] era_days;
	logic [21:0] era_rem;
	logic [4:0]  era_fix;
	logic [17:0] doe_c;

	always_comb begin
		era_days = 22'(era_s2) * 22'(camy_pkg::DAYS_400Y);
		era_rem  = z_s2 - era_days;
		if (era_rem >= 22'(camy_pkg::DAYS_400Y)) begin
			era_fix = era_s2 + 5'd1;
			doe_c   = 18'(era_rem - 22'(camy_pkg::DAYS_400Y));
		end else begin
			era_fix = era_s2;
			doe_c   = era_rem[17:0];
		end
	end

	logic               op_s3;
	logic signed [17:0] cd_s3;
	logic [4:0]         era_s3;
	logic [17:0]        doe_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			op_s3  <= op_s2;
			cd_s3  <= cd_s2;
			era_s3 <= era_fix;
			doe_s3 <= doe_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: century of the era. The last century carries the extra
	// leap day, so the index stops at three.
	// ------------------------------------------------------------------
	logic [1:0]  cent_c;
	logic [17:0] cent_days;

	always_comb begin
		if (doe_s3 >= 18'd109572) begin
			cent_c = 2'd3;
		end else if (doe_s3 >= 18'd73048) begin
			cent_c = 2'd2;
		end else if (doe_s3 >= 18'(camy_pkg::DAYS_100Y)) begin
			cent_c = 2'd1;
		end else begin
			cent_c = 2'd0;
		end
		cent_days = doe_s3 - 18'(cent_c) * 18'(camy_pkg::DAYS_100Y);
	end

	logic               op_s4;
	logic signed [17:0] cd_s4;
	logic [4:0]         era_s4;
	logic [1:0]         cent_s4;
	logic [15:0]        doc_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			op_s4   <= op_s3;
			cd_s4   <= cd_s3;
			era_s4  <= era_s3;
			cent_s4 <= cent_c;
			doc_s4  <= cent_days[15:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: estimate the four-year cycle within the century.
	// ------------------------------------------------------------------
	logic [27:0] cyc_prod;

	assign cyc_prod = 28'(doc_s4) * 28'(camy_pkg::CYC_RECIP);

	logic               op_s5;
	logic signed [17:0] cd_s5;
	logic [4:0]         era_s5;
	logic [1:0]         cent_s5;
	logic [15:0]        doc_s5;
	logic [4:0]         cyc_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			op_s5   <= op_s4;
			cd_s5   <= cd_s4;
			era_s5  <= era_s4;
			cent_s5 <= cent_s4;
			doc_s5  <= doc_s4;
			cyc_s5  <= cyc_prod[26:22];
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: correct the cycle estimate and form the day of the cycle.
	// ------------------------------------------------------------------
	logic [15:0] cyc_rem;
	logic [4:0]  cyc_fix;
	logic [10:0] doq_c;

	always_comb begin
		cyc_rem = doc_s5 - 16'(cyc_s5) * 16'(camy_pkg::DAYS_4Y);
		if (cyc_rem >= 16'(camy_pkg::DAYS_4Y)) begin
			cyc_fix = cyc_s5 + 5'd1;
			doq_c   = 11'(cyc_rem - 16'(camy_pkg::DAYS_4Y));
		end else begin
			cyc_fix = cyc_s5;
			doq_c   = cyc_rem[10:0];
		end
	end

	logic               op_s6;
	logic signed [17:0] cd_s6;
	logic [4:0]         era_s6;
	logic [1:0]         cent_s6;
	logic [4:0]         cyc_s6;
	logic [10:0]        doq_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			op_s6   <= op_s5;
			cd_s6   <= cd_s5;
			era_s6  <= era_s5;
			cent_s6 <= cent_s5;
			cyc_s6  <= cyc_fix;
			doq_s6  <= doq_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: year within the cycle and day of that year.
	// ------------------------------------------------------------------
	logic [1:0]  yoc_c;
	logic [10:0] yoc_days;

	always_comb begin
		if (doq_s6 >= 11'd1095) begin
			yoc_c = 2'd3;
		end else if (doq_s6 >= 11'd730) begin
			yoc_c = 2'd2;
		end else if (doq_s6 >= 11'(camy_pkg::DAYS_1Y)) begin
			yoc_c = 2'd1;
		end else begin
			yoc_c = 2'd0;
		end
		yoc_days = doq_s6 - 11'(yoc_c) * 11'(camy_pkg::DAYS_1Y);
	end

	logic               op_s7;
	logic signed [17:0] cd_s7;
	logic [4:0]         era_s7;
	logic [1:0]         cent_s7;
	logic [4:0]         cyc_s7;
	logic [1:0]         yoc_s7;
	logic [8:0]         doy_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			op_s7   <= op_s6;
			cd_s7   <= cd_s6;
			era_s7  <= era_s6;
			cent_s7 <= cent_s6;
			cyc_s7  <= cyc_s6;
			yoc_s7  <= yoc_c;
			doy_s7  <= yoc_days[8:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: month and day from the March-based day of year, and the
	// year of the era. January and February belong to the next year.
	// ------------------------------------------------------------------
	logic [3:0] mp_c;
	logic [8:0] dom_w;
	logic [3:0] mon_c;
	logic [8:0] yoe_c;

	always_comb begin
		mp_c  = camy_pkg::march_month(doy_s7);
		dom_w = doy_s7 - camy_pkg::march_start(mp_c) + 9'd1;
		mon_c = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
		yoe_c = 9'(cent_s7) * 9'd100 + 9'(cyc_s7) * 9'd4 + 9'(yoc_s7);
	end

	logic               op_s8;
	logic signed [17:0] cd_s8;
	logic [4:0]         era_s8;
	logic [8:0]         yoe_s8;
	logic               jf_s8;
	logic [3:0]         mon_s8;
	logic [4:0]         dom_s8;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			op_s8  <= op_s7;
			cd_s8  <= cd_s7;
			era_s8 <= era_s7;
			yoe_s8 <= yoe_c;
			jf_s8  <= (mp_c >= 4'd10);
			mon_s8 <= mon_c;
			dom_s8 <= dom_w[4:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: civil year.
	// ------------------------------------------------------------------
	logic [14:0] year_w;

	assign year_w = 15'(era_s8) * 15'(camy_pkg::CYC_YEARS) + 15'(yoe_s8) + 15'(jf_s8)
	              - 15'(camy_pkg::CYC_YEARS);

	logic               op_s9;
	logic signed [17:0] cd_s9;
	logic [13:0]        year_s9;
	logic [3:0]         mon_s9;
	logic [4:0]         dom_s9;

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			op_s9   <= op_s8;
			cd_s9   <= cd_s8;
			year_s9 <= year_w[13:0];
			mon_s9  <= mon_s8;
			dom_s9  <= dom_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: shift. Months use the month index year*12 + month-1;
	// years add directly. Both fit a 19-bit signed sum.
	// ------------------------------------------------------------------
	logic [18:0] cd_x;
	logic [18:0] shift_c;

	always_comb begin
		cd_x = {cd_s9[17], cd_s9};
		if (op_s9 == camy_pkg::OP_YEARS) begin
			shift_c = 19'(year_s9) + cd_x;
		end else begin
			shift_c = 19'(year_s9) * 19'(camy_pkg::MONTHS_PER_YEAR)
			        + 19'(mon_s9 - 4'd1) + cd_x;
		end
	end

	logic        op_s10;
	logic [18:0] sum_s10;
	logic [3:0]  mon_s10;
	logic [4:0]  dom_s10;

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			op_s10  <= op_s9;
			sum_s10 <= shift_c;
			mon_s10 <= mon_s9;
			dom_s10 <= dom_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 11: months: estimate index / 12. Years: clamp to 0..9999.
	// ------------------------------------------------------------------
	logic [32:0] d12_prod;
	logic [14:0] ny_c;

	always_comb begin
		d12_prod = 33'(sum_s10[17:0]) * 33'(camy_pkg::DIV12_RECIP);
		if (op_s10 == camy_pkg::OP_YEARS) begin
			if (sum_s10[18]) begin
				ny_c = 15'd0;
			end else if (sum_s10[17:0] > 18'(camy_pkg::YEAR_MAX)) begin
				ny_c = 15'(camy_pkg::YEAR_MAX);
			end else begin
				ny_c = sum_s10[14:0];
			end
		end else begin
			ny_c = d12_prod[32:18];
		end
	end

	logic        op_s11;
	logic        under_s11;
	logic [17:0] sum_s11;
	logic [14:0] ny_s11;
	logic [3:0]  mon_s11;
	logic [4:0]  dom_s11;

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			op_s11    <= op_s10;
			under_s11 <= (op_s10 == camy_pkg::OP_MONTHS) && sum_s10[18];
			sum_s11   <= sum_s10[17:0];
			ny_s11    <= ny_c;
			mon_s11   <= mon_s10;
			dom_s11   <= dom_s10;
		end
	end

	// ------------------------------------------------------------------
	// Stage 12: months: fix the quotient, take the month from the
	// remainder and flag years past the window.
	// ------------------------------------------------------------------
	logic [17:0] m12_rem;
	logic [4:0]  rem5;
	logic [14:0] ny_fix;
	logic [3:0]  nm_c;
	logic [1:0]  sat_c;

	always_comb begin
		m12_rem = sum_s11 - 18'(ny_s11) * 18'(camy_pkg::MONTHS_PER_YEAR);
		rem5    = m12_rem[4:0];
		sat_c   = camy_pkg::SAT_NONE;
		if (op_s11 == camy_pkg::OP_YEARS) begin
			ny_fix = ny_s11;
			nm_c   = mon_s11;
		end else begin
			if (rem5 >= 5'(camy_pkg::MONTHS_PER_YEAR)) begin
				ny_fix = ny_s11 + 15'd1;
				nm_c   = 4'(rem5 - 5'd11);
			end else begin
				ny_fix = ny_s11;
				nm_c   = 4'(rem5 + 5'd1);
			end
			if (under_s11) begin
				sat_c = camy_pkg::SAT_LOW;
			end else if (ny_fix > 15'(camy_pkg::YEAR_MAX)) begin
				sat_c = camy_pkg::SAT_HIGH;
			end
		end
	end

	logic [13:0] ny_s12;
	logic [3:0]  nm_s12;
	logic [4:0]  dom_s12;
	logic [1:0]  sat_s12;

	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			ny_s12  <= ny_fix[13:0];
			nm_s12  <= nm_c;
			dom_s12 <= dom_s11;
			sat_s12 <= sat_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 13: estimate the target year's 400-year cycle.
	// ------------------------------------------------------------------
	logic [27:0] d400_prod;

	assign d400_prod = 28'(ny_s12) * 28'(camy_pkg::DIV400_RECIP);

	logic [13:0] ny_s13;
	logic [4:0]  q400_s13;
	logic [3:0]  nm_s13;
	logic [4:0]  dom_s13;
	logic [1:0]  sat_s13;

	always_ff @(posedge clk) begin
		if (rdy[13]) begin
			ny_s13   <= ny_s12;
			q400_s13 <= d400_prod[26:22];
			nm_s13   <= nm_s12;
			dom_s13  <= dom_s12;
			sat_s13  <= sat_s12;
		end
	end

	// ------------------------------------------------------------------
	// Stage 14: correct the cycle and form the year within it.
	// ------------------------------------------------------------------
	logic [13:0] r400_w;
	logic [4:0]  q400_fix;
	logic [8:0]  r400_c;

	always_comb begin
		r400_w = ny_s13 - 14'(q400_s13) * 14'(camy_pkg::CYC_YEARS);
		if (r400_w >= 14'(camy_pkg::CYC_YEARS)) begin
			q400_fix = q400_s13 + 5'd1;
			r400_c   = 9'(r400_w - 14'(camy_pkg::CYC_YEARS));
		end else begin
			q400_fix = q400_s13;
			r400_c   = r400_w[8:0];
		end
	end

	logic [4:0] q400_s14;
	logic [8:0] r400_s14;
	logic [3:0] nm_s14;
	logic [4:0] dom_s14;
	logic [1:0] sat_s14;

	always_ff @(posedge clk) begin
		if (rdy[14]) begin
			q400_s14 <= q400_fix;
			r400_s14 <= r400_c;
			nm_s14   <= nm_s13;
			dom_s14  <= dom_s13;
			sat_s14  <= sat_s13;
		end
	end

	// ------------------------------------------------------------------
	// Stage 15: leap test and clamp of the day to the month's length.
	// This also turns Feb 29 into Feb 28 in a common year.
	// ------------------------------------------------------------------
	logic       leap_c;
	logic [4:0] len_c;
	logic [4:0] nd_c;

	always_comb begin
		leap_c = (r400_s14[1:0] == 2'd0) && (r400_s14 != 9'd100)
		      && (r400_s14 != 9'd200) && (r400_s14 != 9'd300);
		len_c  = camy_pkg::month_len(nm_s14, leap_c);
		nd_c   = (dom_s14 < len_c) ? dom_s14 : len_c;
	end

	logic [4:0] q400_s15;
	logic [8:0] r400_s15;
	logic [3:0] nm_s15;
	logic [4:0] nd_s15;
	logic       leap_s15;
	logic [1:0] sat_s15;

	always_ff @(posedge clk) begin
		if (rdy[15]) begin
			q400_s15 <= q400_s14;
			r400_s15 <= r400_s14;
			nm_s15   <= nm_s14;
			nd_s15   <= nd_c;
			leap_s15 <= leap_c;
			sat_s15  <= sat_s14;
		end
	end

	// ------------------------------------------------------------------
	// Stage 16: days from 0000-01-01 to January 1 of the target year,
	// and the day offset within that year.
	// ------------------------------------------------------------------
	logic [21:0] base_c;
	logic [8:0]  off_c;

	always_comb begin
		base_c = 22'(q400_s15) * 22'(camy_pkg::DAYS_400Y)
		       + 22'(r400_s15) * 22'(camy_pkg::DAYS_1Y)
		       + 22'(camy_pkg::cycle_leaps(r400_s15));
		off_c  = camy_pkg::cum_days(nm_s15) + 9'(leap_s15 && (nm_s15 > 4'd2))
		       + 9'(nd_s15) - 9'd1;
	end

	logic [21:0] base_s16;
	logic [8:0]  off_s16;
	logic [1:0]  sat_s16;

	always_ff @(posedge clk) begin
		if (rdy[16]) begin
			base_s16 <= base_c;
			off_s16  <= off_c;
			sat_s16  <= sat_s15;
		end
	end

	// ------------------------------------------------------------------
	// Stage 17: back to days since 1970-01-01, with the window limits
	// for month shifts that left the calendar range.
	// ------------------------------------------------------------------
	logic [22:0]        res_w;
	logic signed [22:0] res_c;

	always_comb begin
		res_w = {1'b0, base_s16} + 23'(off_s16) - 23'(camy_pkg::DAY_EPOCH);
		case (sat_s16)
			camy_pkg::SAT_LOW:  res_c = camy_pkg::DAY_MIN;
			camy_pkg::SAT_HIGH: res_c = camy_pkg::DAY_MAX;
			default:            res_c = res_w;
		endcase
	end

	logic signed [22:0] res_s17;

	always_ff @(posedge clk) begin
		if (rdy[17]) begin
			res_s17 <= res_c;
		end
	end

	assign result_day_number = res_s17;

endmodule
